>>> src/mfrc_pkg.sv
// mfrc_pkg: shared types, constants and the byte-wide crc step for the
// mesh frame receive checker. No dependencies.
`default_nettype none

package mfrc_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ADDRESS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL    = 2'd3;

    localparam logic [7:0]  OWN_ADDRESS_RESET   = 8'd1;
    localparam logic [7:0]  ADDRESS_LIMIT_RESET = 8'd16;
    localparam logic [7:0]  BROADCAST_RESET     = 8'd255;
    localparam logic [15:0] CRC_POLY_RESET      = 16'h1021;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // header byte positions
    localparam logic [7:0] BYTE_DEST     = 8'd0;
    localparam logic [7:0] BYTE_SOURCE   = 8'd1;
    localparam logic [7:0] BYTE_SEQ_HIGH = 8'd2;
    localparam logic [7:0] BYTE_SEQ_LOW  = 8'd3;
    localparam logic [7:0] BYTE_FUNC     = 8'd4;

    // frame queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        VERDICT_ACCEPT     = 3'd0,
        VERDICT_BAD_ADDR   = 3'd1,
        VERDICT_OWN_FRAME  = 3'd2,
        VERDICT_CRC_ERROR  = 3'd3,
        VERDICT_NOT_FOR_US = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [7:0]  own_address;
        logic [7:0]  address_limit;
        logic [7:0]  broadcast_address;
        logic [15:0] crc_polynomial;
    } mfrc_cfg_t;

    // one finished frame as handed from front to back
    typedef struct packed {
        logic [7:0]  dest;
        logic [7:0]  source;
        logic [15:0] sequence_no;
        logic [7:0]  func;
        logic [7:0]  length;
        logic        crc_zero;
    } mfrc_frame_t;

    // msb-first crc over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/mesh_frame_receive_checker.sv
// mesh_frame_receive_checker: top level with configuration registers, front,
// frame queue and back. Depends on mfrc_pkg, mfrc_front, mfrc_fifo, mfrc_back.
//
// Usage:
//   s_ channel: one received byte per transaction, s_last_byte on the final
//   byte of a frame. Bytes are taken one per cycle while the queue is not full; the byte-wide crc step
//   in the front finishes in the cycle the byte arrives.
//   m_ channel: one verdict transaction per frame, with the captured header
//   fields and the saturated byte count. After the last byte is taken, the frame
//   record passes through the queue and then the output register, which shows the verdict.
//   With m_ready high, throughput is one byte per cycle, also for back-to-back
//   one-byte frames; the two-entry frame queue and output register set that figure.
//   When the receiver stalls, finished frames fill the queue; s_ready drops
//   only once the queue is full, and the byte in flight is never lost.
//   cfg_ channel: register index and data, always ready; write only while no
//   frame is in progress or pending.
//   Reset (aresetn low, synchronous) restores the register defaults, clears
//   the queue and output, and reloads the crc with all ones.
`default_nettype none

module mesh_frame_receive_checker
    import mfrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_last_byte,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_verdict,
    output logic [7:0]                  m_dest_field,
    output logic [7:0]                  m_source_field,
    output logic [15:0]                 m_sequence_field,
    output logic [7:0]                  m_function_field,
    output logic [7:0]                  m_frame_length,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]            cfg_data
);

    mfrc_cfg_t   cfg_reg;
    logic        q_push, q_pop, q_full, q_empty;
    mfrc_frame_t push_frame, head_frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address       <= OWN_ADDRESS_RESET;
            cfg_reg.address_limit     <= ADDRESS_LIMIT_RESET;
            cfg_reg.broadcast_address <= BROADCAST_RESET;
            cfg_reg.crc_polynomial    <= CRC_POLY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_OWN_ADDRESS:       cfg_reg.own_address       <= cfg_data[7:0];
                REG_ADDRESS_LIMIT:     cfg_reg.address_limit     <= cfg_data[7:0];
                REG_BROADCAST_ADDRESS: cfg_reg.broadcast_address <= cfg_data[7:0];
                REG_CRC_POLYNOMIAL:    cfg_reg.crc_polynomial    <= cfg_data;
                default: ;
            endcase
        end
    end

    mfrc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .crc_polynomial(cfg_reg.crc_polynomial),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_frame       (push_frame)
    );

    mfrc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_frame(push_frame),
        .pop       (q_pop),
        .head_frame(head_frame),
        .full      (q_full),
        .empty     (q_empty)
    );

    mfrc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_frame         (head_frame),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_dest_field    (m_dest_field),
        .m_source_field  (m_source_field),
        .m_sequence_field(m_sequence_field),
        .m_function_field(m_function_field),
        .m_frame_length  (m_frame_length)
    );

    // a frame ending into an idle block passes the queue, then the output register
    a_idle_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_byte && q_empty && !m_valid) |-> ##2 m_valid)
        else $error("verdict missing two cycles after last byte");

    // every frame holds at least its last byte
    a_length_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_length != 8'd0))
        else $error("verdict with zero frame length");

    // short frames carry no sequence number
    a_short_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_frame_length <= BYTE_FUNC)) |-> (m_sequence_field == 16'h0000))
        else $error("sequence reported for short frame");

    // no pop from an empty queue, and no push into a full one without a pop
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty) && !(q_push && q_full && !q_pop))
        else $error("frame queue overrun or underrun");

endmodule

`default_nettype wire

>>> src/mfrc_front.sv
// mfrc_front: takes frame bytes, runs the crc, captures header fields and
// pushes one frame record per last byte. Depends on mfrc_pkg.
`default_nettype none

module mfrc_front
    import mfrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    input  wire logic [15:0] crc_polynomial,
    input  wire logic        q_full,
    output logic             q_push,
    output mfrc_frame_t      q_frame
);

    localparam logic [7:0] MaxCount = 8'(MAX_FRAME_BYTES);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  source_reg, source_next;
    logic [15:0] seq_reg, seq_next;
    logic [7:0]  func_reg, func_next;
    logic        fire;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;
    assign q_push  = fire && s_last_byte;

    always_comb begin
        dest_next   = dest_reg;
        source_next = source_reg;
        seq_next    = seq_reg;
        func_next   = func_reg;
        unique case (count_reg)
            BYTE_DEST:     dest_next      = s_data_byte;
            BYTE_SOURCE:   source_next    = s_data_byte;
            BYTE_SEQ_HIGH: seq_next[15:8] = s_data_byte;
            BYTE_SEQ_LOW:  seq_next[7:0]  = s_data_byte;
            BYTE_FUNC:     func_next      = s_data_byte;
            default: ;
        endcase
        crc_next   = crc_byte(crc_reg, s_data_byte, crc_polynomial);
        count_next = (count_reg < MaxCount) ? count_reg + 8'd1 : count_reg;
    end

    always_comb begin
        q_frame.dest        = dest_next;
        q_frame.source      = source_next;
        // sequence only counts once the function byte is in
        q_frame.sequence_no = (count_next > BYTE_FUNC) ? seq_next : 16'h0000;
        q_frame.func        = func_next;
        q_frame.length      = count_next;
        q_frame.crc_zero    = (crc_next == 16'h0000);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            crc_reg    <= CRC_INIT;
            count_reg  <= 8'd0;
            dest_reg   <= 8'd0;
            source_reg <= 8'd0;
            seq_reg    <= 16'h0000;
            func_reg   <= 8'd0;
        end else if (fire) begin
            crc_reg    <= crc_next;
            count_reg  <= count_next;
            dest_reg   <= dest_next;
            source_reg <= source_next;
            seq_reg    <= seq_next;
            func_reg   <= func_next;
        end
    end

endmodule

`default_nettype wire

>>> src/mfrc_fifo.sv
// mfrc_fifo: short queue of finished frame records between front and back.
// Depends on mfrc_pkg.
`default_nettype none

module mfrc_fifo
    import mfrc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire mfrc_frame_t push_frame,
    input  wire logic  pop,
    output mfrc_frame_t head_frame,
    output logic       full,
    output logic       empty
);

    mfrc_frame_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_frame = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

`default_nettype wire

>>> src/mfrc_back.sv
// mfrc_back: takes frame records from the queue, decides the verdict and
// holds the result in an output register. Depends on mfrc_pkg.
`default_nettype none

module mfrc_back
    import mfrc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mfrc_cfg_t   cfg,
    input  wire logic        q_empty,
    input  wire mfrc_frame_t q_frame,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_verdict,
    output logic [7:0]       m_dest_field,
    output logic [7:0]       m_source_field,
    output logic [15:0]      m_sequence_field,
    output logic [7:0]       m_function_field,
    output logic [7:0]       m_frame_length
);

    logic        valid_reg;
    verdict_t    verdict_next, verdict_reg;
    mfrc_frame_t frame_reg;
    logic        addr_ok, dest_match;

    assign q_pop = !q_empty && (!valid_reg || m_ready);

    always_comb begin
        addr_ok = (q_frame.source < cfg.address_limit) &&
                  ((q_frame.dest < cfg.address_limit) ||
                   (q_frame.dest == cfg.broadcast_address));
        dest_match = (q_frame.dest == cfg.own_address) ||
                     (q_frame.dest == cfg.broadcast_address);
        if (!addr_ok) begin
            verdict_next = VERDICT_BAD_ADDR;
        end else if (q_frame.source == cfg.own_address) begin
            verdict_next = VERDICT_OWN_FRAME;
        end else if (!q_frame.crc_zero) begin
            verdict_next = VERDICT_CRC_ERROR;
        end else if (!dest_match) begin
            verdict_next = VERDICT_NOT_FOR_US;
        end else begin
            verdict_next = VERDICT_ACCEPT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            verdict_reg <= verdict_next;
            frame_reg   <= q_frame;
        end
    end

    assign m_valid          = valid_reg;
    assign m_verdict        = verdict_reg;
    assign m_dest_field     = frame_reg.dest;
    assign m_source_field   = frame_reg.source;
    assign m_sequence_field = frame_reg.sequence_no;
    assign m_function_field = frame_reg.func;
    assign m_frame_length   = frame_reg.length;

endmodule

`default_nettype wire

>>> tb/sv/mesh_frame_receive_checker_test.sv
// mesh_frame_receive_checker_test: self-checking bench for the mesh frame receive checker.
// Streams directed and random frames under bursty input and a stalling receiver, and predicts
// every verdict. Depends on mfrc_pkg and mesh_frame_receive_checker.

module mesh_frame_receive_checker_test;
    import mfrc_pkg::*;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_ITEMS     = 125;
    localparam int RANDOM_PHASES   = 9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } frame_byte_t;

    typedef struct {
        verdict_t    verdict;
        logic [7:0]  dest;
        logic [7:0]  source;
        logic [15:0] sequence_no;
        logic [7:0]  func;
        logic [7:0]  length;
    } frame_verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte = 8'h00;
    logic                   s_last_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [2:0]             m_verdict;
    logic [7:0]             m_dest_field;
    logic [7:0]             m_source_field;
    logic [15:0]            m_sequence_field;
    logic [7:0]             m_function_field;
    logic [7:0]             m_frame_length;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_OWN_ADDRESS;
    logic [15:0]            cfg_data = 16'h0000;

    // byte stream waiting for the driver, and verdicts still owed by the block
    frame_byte_t    byte_queue[$];
    frame_verdict_t verdicts_due[$];

    // predictor copy of registers and frame state
    mfrc_cfg_t   node_cfg;
    logic [15:0] frame_crc;
    logic [7:0]  frame_count;
    logic [7:0]  cap_dest;
    logic [7:0]  cap_source;
    logic [15:0] cap_seq;
    logic [7:0]  cap_func;

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left;
    int          gap_left;
    frame_byte_t next_byte;
    int          rx_mode = 0;
    int          rx_mode_left = 0;
    int          rx_tick = 0;
    int          hold_left = 0;
    int          hold_requests = 0;
    int          holds_served = 0;

    mesh_frame_receive_checker #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_verdict(m_verdict),
        .m_dest_field(m_dest_field),
        .m_source_field(m_source_field),
        .m_sequence_field(m_sequence_field),
        .m_function_field(m_function_field),
        .m_frame_length(m_frame_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    // bit-serial form of the msb-first crc: feedback is top bit xor incoming bit
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc,
                                                   input logic [7:0]  b,
                                                   input logic [15:0] poly);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
        end
        return c;
    endfunction

    function automatic void restart_frame();
        frame_crc   = CRC_INIT;
        frame_count = 8'd0;
        cap_dest    = 8'd0;
        cap_source  = 8'd0;
        cap_seq     = 16'd0;
        cap_func    = 8'd0;
    endfunction

    // fold one accepted byte into the frame; on the last byte queue the verdict
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        frame_verdict_t v;
        logic           addr_ok;
        case (frame_count)
            BYTE_DEST:     cap_dest = b;
            BYTE_SOURCE:   cap_source = b;
            BYTE_SEQ_HIGH: cap_seq[15:8] = b;
            BYTE_SEQ_LOW:  cap_seq[7:0] = b;
            BYTE_FUNC:     cap_func = b;
            default: ;
        endcase
        frame_crc = crc_shift_byte(frame_crc, b, node_cfg.crc_polynomial);
        if (frame_count != 8'(MAX_FRAME_BYTES)) begin
            frame_count = frame_count + 8'd1;
        end
        if (last) begin
            addr_ok = (cap_source < node_cfg.address_limit) &&
                      ((cap_dest < node_cfg.address_limit) ||
                       (cap_dest == node_cfg.broadcast_address));
            if (!addr_ok) begin
                v.verdict = VERDICT_BAD_ADDR;
            end else if (cap_source == node_cfg.own_address) begin
                v.verdict = VERDICT_OWN_FRAME;
            end else if (frame_crc != 16'h0000) begin
                v.verdict = VERDICT_CRC_ERROR;
            end else if (cap_dest != node_cfg.own_address &&
                         cap_dest != node_cfg.broadcast_address) begin
                v.verdict = VERDICT_NOT_FOR_US;
            end else begin
                v.verdict = VERDICT_ACCEPT;
            end
            v.dest        = cap_dest;
            v.source      = cap_source;
            // sequence only reported once the function byte has arrived
            v.sequence_no = (frame_count > 8'd4) ? cap_seq : 16'd0;
            v.func        = cap_func;
            v.length      = frame_count;
            verdicts_due.push_back(v);
            restart_frame();
        end
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0d] verdict check failed: %s", cycle_count, what);
        end
    endtask

    // register model follows every accepted write transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            node_cfg.own_address       = OWN_ADDRESS_RESET;
            node_cfg.address_limit     = ADDRESS_LIMIT_RESET;
            node_cfg.broadcast_address = BROADCAST_RESET;
            node_cfg.crc_polynomial    = CRC_POLY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_OWN_ADDRESS:       node_cfg.own_address = cfg_data[7:0];
                REG_ADDRESS_LIMIT:     node_cfg.address_limit = cfg_data[7:0];
                REG_BROADCAST_ADDRESS: node_cfg.broadcast_address = cfg_data[7:0];
                REG_CRC_POLYNOMIAL:    node_cfg.crc_polynomial = cfg_data;
                default: ;
            endcase
        end
    end

    // byte driver: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = $urandom_range(1, 48);
            gap_left = 0;
            restart_frame();
        end else begin
            if (s_valid && s_ready) begin
                absorb_byte(s_data_byte, s_last_byte);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    next_byte = byte_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= next_byte.data_byte;
                    s_last_byte <= next_byte.last_byte;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall modes that change over time, plus requested long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_requests > holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 300);
            end else begin
                rx_mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_tick % 4 == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // verdict monitor
    always @(posedge aclk) begin
        frame_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                log_mismatch($sformatf("unexpected transaction v=%0d d=%02h s=%02h len=%0d",
                                       m_verdict, m_dest_field, m_source_field,
                                       m_frame_length));
            end else begin
                want = verdicts_due.pop_front();
                if (m_verdict !== want.verdict || m_dest_field !== want.dest ||
                    m_source_field !== want.source ||
                    m_sequence_field !== want.sequence_no ||
                    m_function_field !== want.func || m_frame_length !== want.length) begin
                    log_mismatch($sformatf(
                        "exp v=%0d d=%02h s=%02h seq=%04h f=%02h len=%0d, got v=%0d d=%02h s=%02h seq=%04h f=%02h len=%0d",
                        want.verdict, want.dest, want.source, want.sequence_no,
                        want.func, want.length, m_verdict, m_dest_field,
                        m_source_field, m_sequence_field, m_function_field,
                        m_frame_length));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input mfrc_cfg_t plan);
        write_reg(REG_OWN_ADDRESS, {8'h00, plan.own_address});
        write_reg(REG_ADDRESS_LIMIT, {8'h00, plan.address_limit});
        write_reg(REG_BROADCAST_ADDRESS, {8'h00, plan.broadcast_address});
        write_reg(REG_CRC_POLYNOMIAL, plan.crc_polynomial);
    endtask

    // queue one frame; seal appends the big-endian crc so a clean frame leaves zero
    task automatic queue_frame(input logic [7:0] body[$], input logic [15:0] poly,
                               input bit seal, input bit spoil);
        logic [15:0] crc;
        int          pos;
        crc = CRC_INIT;
        if (seal) begin
            foreach (body[i]) crc = crc_shift_byte(crc, body[i], poly);
            body.push_back(crc[15:8]);
            body.push_back(crc[7:0]);
        end
        if (spoil) begin
            pos = $urandom_range(0, body.size() - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (body[i]) begin
            byte_queue.push_back('{data_byte: body[i], last_byte: (i == body.size() - 1)});
        end
    endtask

    function automatic logic [7:0] pick_address(input mfrc_cfg_t plan, input bit is_dest);
        int r;
        r = $urandom_range(0, 9);
        if (is_dest && r < 4) return plan.own_address;
        if (is_dest && r < 6) return plan.broadcast_address;
        if (!is_dest && r == 0) return plan.own_address;
        if (r < 9 && plan.address_limit != 8'd0) begin
            return 8'($urandom_range(0, plan.address_limit - 1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random_frame(input mfrc_cfg_t plan);
        logic [7:0] body[$];
        int         kind;
        int         body_len;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // line noise: raw bytes with no crc
            body_len = $urandom_range(1, 12);
            repeat (body_len) body.push_back(8'($urandom_range(0, 255)));
            queue_frame(body, plan.crc_polynomial, 1'b0, 1'b0);
        end else begin
            if (kind < 18) body_len = $urandom_range(1, 4);
            else if (kind < 95) body_len = $urandom_range(5, 14);
            else if (kind < 99) body_len = $urandom_range(15, 48);
            else body_len = $urandom_range(250, 290);
            for (int i = 0; i < body_len; i++) begin
                if (i == 0) body.push_back(pick_address(plan, 1'b1));
                else if (i == 1) body.push_back(pick_address(plan, 1'b0));
                else body.push_back(8'($urandom_range(0, 255)));
            end
            queue_frame(body, plan.crc_polynomial, $urandom_range(0, 19) != 0,
                        $urandom_range(0, 7) == 0);
        end
    endtask

    // idle means no byte pending or in flight and no verdict owed
    task automatic wait_idle();
        do @(posedge aclk);
        while (byte_queue.size() != 0 || s_valid || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        mfrc_cfg_t  plan;
        logic [7:0] body[$];
        int         phase_items;
        int         start_size;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames under reset register values
        plan = '{OWN_ADDRESS_RESET, ADDRESS_LIMIT_RESET, BROADCAST_RESET, CRC_POLY_RESET};
        body = '{8'hFF};
        queue_frame(body, plan.crc_polynomial, 1'b0, 1'b0);
        body = '{8'h00};
        queue_frame(body, plan.crc_polynomial, 1'b0, 1'b0);
        body = '{8'h01, 8'h02, 8'hAB, 8'hCD, 8'h55};
        queue_frame(body, plan.crc_polynomial, 1'b1, 1'b0);
        body = '{8'h03, 8'h01};
        queue_frame(body, plan.crc_polynomial, 1'b1, 1'b0);
        body = '{8'h20, 8'h02};
        queue_frame(body, plan.crc_polynomial, 1'b0, 1'b0);
        body = '{8'h05, 8'h02, 8'h80, 8'h01, 8'h7F, 8'h00};
        queue_frame(body, plan.crc_polynomial, 1'b1, 1'b0);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: plan = '{8'd0, 8'd255, 8'd255, 16'h1021};
                1: plan = '{8'd255, 8'd0, 8'd0, 16'hFFFF};
                2: plan = '{8'd254, 8'd255, 8'd0, 16'h0000};
                3: plan = '{8'd1, 8'd16, 8'd255, 16'h8005};
                default: plan = '{8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
            endcase
            program_regs(plan);
            // let the receiver sit still while frames keep coming
            if (ph == 3) hold_requests++;
            start_size = byte_queue.size();
            if (ph == 2) begin
                // long clean frame: length count saturates, crc keeps running
                body = {};
                body.push_back(plan.own_address);
                body.push_back(8'd3);
                repeat (268) body.push_back(8'($urandom_range(0, 255)));
                queue_frame(body, plan.crc_polynomial, 1'b1, 1'b0);
            end
            phase_items = byte_queue.size() - start_size;
            while (phase_items < PHASE_ITEMS) begin
                start_size = byte_queue.size();
                queue_random_frame(plan);
                phase_items += byte_queue.size() - start_size;
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && verdicts_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
